FILE: rtl/bldim_pkg.sv
// shared types, constants and the perceptual level map for the backlight auto-dim unit
// no dependencies
`timescale 1ns / 1ps

package bldim_pkg;

    localparam int IdleW    = 20;
    localparam int LevelW   = 7;
    localparam int TmoW     = 8;
    localparam int TmoMsW   = 18;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 8;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_USER_LEVEL      = 3'd0,
        CFG_AUTODIM_ENABLE  = 3'd1,
        CFG_TIMEOUT_SECONDS = 3'd2,
        CFG_DIM_LEVEL       = 3'd3,
        CFG_RAMP_STEP       = 3'd4
    } cfg_idx_t;

    localparam logic [LevelW-1:0] USER_LEVEL_RST      = 7'd80;
    localparam logic              AUTODIM_ENABLE_RST  = 1'b1;
    localparam logic [TmoW-1:0]   TIMEOUT_SECONDS_RST = 8'd120;
    localparam logic [LevelW-1:0] DIM_LEVEL_RST       = 7'd10;
    localparam logic [LevelW-1:0] RAMP_STEP_RST       = 7'd4;

    localparam logic [LevelW-1:0] LEVEL_MAX = 7'd100;
    localparam logic [LevelW-1:0] STEP_MIN  = 7'd1;
    localparam logic [TmoMsW-1:0] MS_PER_S  = 18'd1000;

    typedef struct packed {
        logic [LevelW-1:0] user_level;
        logic              autodim_enable;
        logic [TmoW-1:0]   timeout_seconds;
        logic [LevelW-1:0] dim_level;
        logic [LevelW-1:0] ramp_step;
    } cfg_t;

    typedef struct packed {
        logic [LevelW-1:0] level;
        logic              valid;
        logic              dimmed;
    } state_t;

    typedef struct packed {
        state_t nxt;
        logic   emit;
    } decision_t;

    // round(10*sqrt(s)), zero maps to zero, 100 and above saturate
    function automatic logic [LevelW-1:0] map_level(input logic [LevelW-1:0] s);
        logic [LevelW-1:0] m;
        case (s)
            7'd0:   m = 7'd0;
            7'd1:   m = 7'd10;
            7'd2:   m = 7'd14;
            7'd3:   m = 7'd17;
            7'd4:   m = 7'd20;
            7'd5:   m = 7'd22;
            7'd6:   m = 7'd24;
            7'd7:   m = 7'd26;
            7'd8:   m = 7'd28;
            7'd9:   m = 7'd30;
            7'd10:  m = 7'd32;
            7'd11:  m = 7'd33;
            7'd12:  m = 7'd35;
            7'd13:  m = 7'd36;
            7'd14:  m = 7'd37;
            7'd15:  m = 7'd39;
            7'd16:  m = 7'd40;
            7'd17:  m = 7'd41;
            7'd18:  m = 7'd42;
            7'd19:  m = 7'd44;
            7'd20:  m = 7'd45;
            7'd21:  m = 7'd46;
            7'd22:  m = 7'd47;
            7'd23:  m = 7'd48;
            7'd24:  m = 7'd49;
            7'd25:  m = 7'd50;
            7'd26:  m = 7'd51;
            7'd27:  m = 7'd52;
            7'd28:  m = 7'd53;
            7'd29:  m = 7'd54;
            7'd30:  m = 7'd55;
            7'd31:  m = 7'd56;
            7'd32, 7'd33: m = 7'd57;
            7'd34:  m = 7'd58;
            7'd35:  m = 7'd59;
            7'd36:  m = 7'd60;
            7'd37:  m = 7'd61;
            7'd38, 7'd39: m = 7'd62;
            7'd40:  m = 7'd63;
            7'd41:  m = 7'd64;
            7'd42:  m = 7'd65;
            7'd43, 7'd44: m = 7'd66;
            7'd45:  m = 7'd67;
            7'd46:  m = 7'd68;
            7'd47, 7'd48: m = 7'd69;
            7'd49:  m = 7'd70;
            7'd50, 7'd51: m = 7'd71;
            7'd52:  m = 7'd72;
            7'd53, 7'd54: m = 7'd73;
            7'd55:  m = 7'd74;
            7'd56, 7'd57: m = 7'd75;
            7'd58:  m = 7'd76;
            7'd59, 7'd60: m = 7'd77;
            7'd61:  m = 7'd78;
            7'd62, 7'd63: m = 7'd79;
            7'd64:  m = 7'd80;
            7'd65, 7'd66: m = 7'd81;
            7'd67, 7'd68: m = 7'd82;
            7'd69:  m = 7'd83;
            7'd70, 7'd71: m = 7'd84;
            7'd72, 7'd73: m = 7'd85;
            7'd74:  m = 7'd86;
            7'd75, 7'd76: m = 7'd87;
            7'd77, 7'd78: m = 7'd88;
            7'd79, 7'd80: m = 7'd89;
            7'd81:  m = 7'd90;
            7'd82, 7'd83: m = 7'd91;
            7'd84, 7'd85: m = 7'd92;
            7'd86, 7'd87: m = 7'd93;
            7'd88, 7'd89: m = 7'd94;
            7'd90, 7'd91: m = 7'd95;
            7'd92, 7'd93: m = 7'd96;
            7'd94, 7'd95: m = 7'd97;
            7'd96, 7'd97: m = 7'd98;
            7'd98, 7'd99: m = 7'd99;
            default: m = LEVEL_MAX;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/bldim_policy.sv
// per-tick dimming decision: dim entry, snap back and bounded fade of the applied level
// depends on bldim_pkg
`timescale 1ns / 1ps

module bldim_policy (
    input  bldim_pkg::cfg_t                    cfg,
    input  logic [bldim_pkg::IdleW-1:0]        idle_ms,
    input  bldim_pkg::state_t                  cur,
    output bldim_pkg::decision_t               dec
);
    import bldim_pkg::*;

    logic [TmoMsW-1:0] tmo_ms;
    logic              due;
    logic              snap;
    logic              dim_n;
    logic [LevelW-1:0] user_map;
    logic [LevelW-1:0] dim_tgt;
    logic [LevelW-1:0] target;
    logic [LevelW-1:0] step;
    logic [LevelW-1:0] diff;
    logic              up;
    logic [LevelW-1:0] ramped;
    logic [LevelW-1:0] new_level;

    assign tmo_ms   = TmoMsW'(cfg.timeout_seconds) * MS_PER_S;
    assign due      = cfg.autodim_enable && (idle_ms >= IdleW'(tmo_ms));
    assign snap     = !due && cur.dimmed;
    assign dim_n    = due;
    assign user_map = map_level(cfg.user_level);
    assign dim_tgt  = (cfg.dim_level > LEVEL_MAX) ? LEVEL_MAX : cfg.dim_level;
    assign target   = dim_n ? dim_tgt : user_map;
    assign step     = (cfg.ramp_step == '0) ? STEP_MIN : cfg.ramp_step;
    assign up       = cur.level < target;
    assign diff     = up ? (target - cur.level) : (cur.level - target);

    always_comb
    begin
        if (diff > step)
        begin
            ramped = up ? (cur.level + step) : (cur.level - step);
        end
        else
        begin
            ramped = target;
        end
    end

    // snap back and first tick apply directly, otherwise fade
    always_comb
    begin
        if (snap || !cur.valid)
        begin
            new_level = target;
        end
        else
        begin
            new_level = ramped;
        end
    end

    always_comb
    begin
        dec.emit       = !(cur.valid && (new_level == cur.level));
        dec.nxt.dimmed = dim_n;
        dec.nxt.valid  = 1'b1;
        dec.nxt.level  = dec.emit ? new_level : cur.level;
    end

endmodule

FILE: rtl/backlight_autodim_ramp_unit.sv
// backlight auto-dim unit: config registers, input register, policy and result register
// an accepted item waits in the input register while stalled, then its result is registered
// throughput: one item per cycle if not stalled; an unchanged brightness gives no result
// reset: config returns to its defaults, nothing is applied yet and dimming is off
// depends on bldim_pkg and bldim_policy
`timescale 1ns / 1ps

module backlight_autodim_ramp_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bldim_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [bldim_pkg::CfgDataW-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bldim_pkg::IdleW-1:0]          idle_ms,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bldim_pkg::LevelW-1:0]         brightness_pct,
    output logic                                 is_dimmed
);
    import bldim_pkg::*;

    cfg_t              cfg_reg;
    state_t            state_reg;
    decision_t         dec;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [IdleW-1:0]  s1_idle_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [LevelW-1:0] out_level_reg;
    logic              out_dimmed_reg;
    logic              out_free;
    logic              fire;

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.user_level      <= USER_LEVEL_RST;
            cfg_reg.autodim_enable  <= AUTODIM_ENABLE_RST;
            cfg_reg.timeout_seconds <= TIMEOUT_SECONDS_RST;
            cfg_reg.dim_level       <= DIM_LEVEL_RST;
            cfg_reg.ramp_step       <= RAMP_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_USER_LEVEL:      cfg_reg.user_level      <= cfg_data[LevelW-1:0];
                CFG_AUTODIM_ENABLE:  cfg_reg.autodim_enable  <= cfg_data[0];
                CFG_TIMEOUT_SECONDS: cfg_reg.timeout_seconds <= cfg_data[TmoW-1:0];
                CFG_DIM_LEVEL:       cfg_reg.dim_level       <= cfg_data[LevelW-1:0];
                CFG_RAMP_STEP:       cfg_reg.ramp_step       <= cfg_data[LevelW-1:0];
                default:             ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    bldim_policy u_policy (
        .cfg     (cfg_reg),
        .idle_ms (s1_idle_reg),
        .cur     (state_reg),
        .dec     (dec)
    );

    always_comb
    begin
        s1_valid_next = in_stall ? s1_valid_reg : in_valid;
    end

    always_comb
    begin
        if (fire && dec.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                state_reg <= dec.nxt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_idle_reg <= idle_ms;
        end
        if (fire && dec.emit)
        begin
            out_level_reg  <= dec.nxt.level;
            out_dimmed_reg <= dec.nxt.dimmed;
        end
    end

    assign out_valid      = out_valid_reg;
    assign brightness_pct = out_level_reg;
    assign is_dimmed      = out_dimmed_reg;

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && dec.emit |=> out_valid_reg)
        else $error("emitted item did not reach the output register");

    a_out_matches_applied: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg.valid && out_level_reg == state_reg.level))
        else $error("pending result differs from applied level");

    a_applied_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.valid |=> state_reg.valid)
        else $error("applied flag dropped");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_level_reg <= LEVEL_MAX))
        else $error("brightness out of range");

endmodule

FILE: test/tb_backlight_autodim_ramp_unit.sv
// self-checking testbench for backlight_autodim_ramp_unit: directed table, then random tick phases
// expected brightness updates come from the table or an in-bench policy predictor; depends on bldim_pkg and the rtl
`timescale 1ns / 1ps

module tb_backlight_autodim_ramp_unit;

    import bldim_pkg::*;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_CFG
    } row_kind_t;

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_QUIET,
        EXP_GIVEN
    } row_exp_t;

    typedef struct packed {
        row_kind_t         kind;
        cfg_idx_t          idx;
        logic [IdleW-1:0]  arg;
        row_exp_t          exp_kind;
        logic [LevelW-1:0] lvl;
        logic              dim;
    } dir_row_t;

    typedef struct packed {
        logic [LevelW-1:0] level;
        logic              dimmed;
    } shown_t;

    localparam int DIR_ROWS    = 38;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    cfg_idx_t            cfg_index = CFG_USER_LEVEL;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [IdleW-1:0]    idle_ms = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [LevelW-1:0]   brightness_pct;
    logic                is_dimmed;

    // shadow registers and policy state
    logic [LevelW-1:0] m_user = USER_LEVEL_RST;
    logic              m_en = AUTODIM_ENABLE_RST;
    logic [TmoW-1:0]   m_tmo = TIMEOUT_SECONDS_RST;
    logic [LevelW-1:0] m_dim = DIM_LEVEL_RST;
    logic [LevelW-1:0] m_step = RAMP_STEP_RST;
    logic [LevelW-1:0] m_applied = '0;
    logic              m_valid = 1'b0;
    logic              m_dimmed = 1'b0;

    shown_t      brightness_q[$];
    int unsigned mismatches = 0;
    int unsigned ticks_sent = 0;
    int unsigned updates_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned send_gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    logic [IdleW-1:0] idle_track = '0;

    dir_row_t script [DIR_ROWS] = '{
        '{ROW_TICK, CFG_USER_LEVEL, 20'd0, EXP_GIVEN, 7'd89, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd0, EXP_QUIET, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd120000, EXP_GIVEN, 7'd85, 1'b1},
        '{ROW_TICK, CFG_USER_LEVEL, 20'hFFFFF, EXP_GIVEN, 7'd81, 1'b1},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd119999, EXP_GIVEN, 7'd89, 1'b0},
        '{ROW_CFG, CFG_DIM_LEVEL, 20'd127, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_RAMP_STEP, 20'd0, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_USER_LEVEL, 20'd100, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_TIMEOUT_SECONDS, 20'd0, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd0, EXP_GIVEN, 7'd90, 1'b1},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd0, EXP_GIVEN, 7'd91, 1'b1},
        '{ROW_CFG, CFG_AUTODIM_ENABLE, 20'd0, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'hFFFFF, EXP_GIVEN, 7'd100, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd0, EXP_QUIET, 7'd0, 1'b0},
        '{ROW_CFG, CFG_USER_LEVEL, 20'd0, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_RAMP_STEP, 20'd127, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd0, EXP_GIVEN, 7'd0, 1'b0},
        '{ROW_CFG, CFG_USER_LEVEL, 20'd127, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'hFFFFF, EXP_GIVEN, 7'd100, 1'b0},
        '{ROW_CFG, CFG_USER_LEVEL, 20'd1, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_AUTODIM_ENABLE, 20'd1, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_TIMEOUT_SECONDS, 20'd255, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_DIM_LEVEL, 20'd0, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_RAMP_STEP, 20'd1, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd254999, EXP_GIVEN, 7'd99, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd255000, EXP_GIVEN, 7'd98, 1'b1},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd0, EXP_GIVEN, 7'd10, 1'b0},
        '{ROW_CFG, CFG_USER_LEVEL, 20'd5, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_RAMP_STEP, 20'd100, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd1000, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_TIMEOUT_SECONDS, 20'd5, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_DIM_LEVEL, 20'd100, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd5000, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd4999, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_CFG, CFG_USER_LEVEL, 20'd99, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'h55555, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'hAAAAA, EXP_MODEL, 7'd0, 1'b0},
        '{ROW_TICK, CFG_USER_LEVEL, 20'd0, EXP_MODEL, 7'd0, 1'b0}
    };

    backlight_autodim_ramp_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .idle_ms        (idle_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .brightness_pct (brightness_pct),
        .is_dimmed      (is_dimmed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // largest n in 0..100 with (2n-1)^2 <= 400*s
    function automatic logic [LevelW-1:0] perceived(input logic [LevelW-1:0] s);
        int n;
        if (s == '0)
            return '0;
        if (s >= LEVEL_MAX)
            return LEVEL_MAX;
        n = 100;
        while ((2 * n - 1) * (2 * n - 1) > 400 * int'(s))
            n--;
        if (n < 5)
            n = 5;
        return n[LevelW-1:0];
    endfunction

    task automatic advance_policy(input logic [IdleW-1:0] idle, output logic fire,
                                  output shown_t shown);
        logic              due;
        logic              snap;
        logic [LevelW-1:0] goal;
        logic [LevelW-1:0] stride;
        logic [LevelW-1:0] lvl;
        due  = m_en && (32'(idle) >= 32'(m_tmo) * 32'd1000);
        snap = 1'b0;
        if (due)
            m_dimmed = 1'b1;
        else if (m_dimmed)
        begin
            m_dimmed = 1'b0;
            snap = 1'b1;
        end
        if (m_dimmed)
            goal = (m_dim > LEVEL_MAX) ? LEVEL_MAX : m_dim;
        else
            goal = perceived(m_user);
        if (snap || !m_valid)
            lvl = goal;
        else
        begin
            stride = (m_step == '0) ? STEP_MIN : m_step;
            if (m_applied < goal)
                lvl = (goal - m_applied > stride) ? m_applied + stride : goal;
            else
                lvl = (m_applied - goal > stride) ? m_applied - stride : goal;
        end
        fire         = !m_valid || (lvl != m_applied);
        m_applied    = lvl;
        m_valid      = 1'b1;
        shown.level  = lvl;
        shown.dimmed = m_dimmed;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_USER_LEVEL:      m_user = val[LevelW-1:0];
            CFG_AUTODIM_ENABLE:  m_en = val[0];
            CFG_TIMEOUT_SECONDS: m_tmo = val[TmoW-1:0];
            CFG_DIM_LEVEL:       m_dim = val[LevelW-1:0];
            CFG_RAMP_STEP:       m_step = val[LevelW-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic send_tick(input logic [IdleW-1:0] v, output logic fire, output shown_t shown);
        while ($urandom_range(99) < send_gap_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        idle_ms  <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ticks_sent++;
        advance_policy(v, fire, shown);
    endtask

    // stop sending, wait out pending updates and any tick still in flight
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (brightness_q.size() != 0 && waited < 3000)
        begin
            @(posedge clk);
            waited++;
        end
        if (brightness_q.size() != 0)
        begin
            report_mismatch("updates never delivered", brightness_q.size(), 0);
            brightness_q.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // receiver: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        shown_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            updates_seen++;
            if (brightness_q.size() == 0)
                report_mismatch("update with nothing pending", brightness_pct, -1);
            else
            begin
                want = brightness_q.pop_front();
                if (brightness_pct !== want.level)
                    report_mismatch("brightness_pct", brightness_pct, want.level);
                if (is_dimmed !== want.dimmed)
                    report_mismatch("is_dimmed", is_dimmed, want.dimmed);
            end
        end
    end

    initial
    begin
        dir_row_t          row;
        logic              fire;
        shown_t            shown;
        logic [LevelW-1:0] u_val;
        logic              e_val;
        logic [TmoW-1:0]   t_val;
        logic [LevelW-1:0] d_val;
        logic [LevelW-1:0] s_val;
        logic [31:0]       sum;
        int unsigned       lim;
        int unsigned       r;
        int                i;
        int                phase;
        int                n;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            row = script[i];
            if (row.kind == ROW_CFG)
            begin
                drain_results();
                write_reg(row.idx, row.arg[CfgDataW-1:0]);
            end
            else
            begin
                send_tick(row.arg, fire, shown);
                if (row.exp_kind == EXP_GIVEN)
                    brightness_q.push_back('{row.lvl, row.dim});
                else if (row.exp_kind == EXP_MODEL && fire)
                    brightness_q.push_back(shown);
            end
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    u_val = 7'd100; e_val = 1'b1; t_val = 8'd5; d_val = 7'd0; s_val = 7'd1;
                end
                1:
                begin
                    u_val = 7'd5; e_val = 1'b1; t_val = 8'd240; d_val = 7'd100; s_val = 7'd100;
                end
                2:
                begin
                    u_val = 7'd127; e_val = 1'b0; t_val = 8'd0; d_val = 7'd127; s_val = 7'd0;
                end
                3:
                begin
                    u_val = 7'd0; e_val = 1'b1; t_val = 8'd0; d_val = 7'd50; s_val = 7'd127;
                end
                default:
                begin
                    u_val = 7'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                          : $urandom_range(100, 5));
                    e_val = ($urandom_range(3) != 0);
                    t_val = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                          : $urandom_range(30, 5));
                    d_val = 7'(($urandom_range(4) == 0) ? $urandom_range(127)
                                                          : $urandom_range(100));
                    s_val = 7'(($urandom_range(4) == 0) ? $urandom_range(127)
                                                          : $urandom_range(10, 1));
                end
            endcase
            write_reg(CFG_USER_LEVEL, {1'b0, u_val});
            write_reg(CFG_AUTODIM_ENABLE, {7'd0, e_val});
            write_reg(CFG_TIMEOUT_SECONDS, t_val);
            write_reg(CFG_DIM_LEVEL, {1'b0, d_val});
            write_reg(CFG_RAMP_STEP, {1'b0, s_val});
            case (phase % 4)
                0:       begin send_gap_pct = 0;  stall_pct = 0;  end
                1:       begin send_gap_pct = 58; stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  stall_pct = 58; end
                default: begin send_gap_pct = 34; stall_pct = 34; end
            endcase

            for (n = 0; n < PHASE_TICKS; n++)
            begin
                if (phase == 0 && n == 60)
                    hold_reqs++;
                // mostly growing idle time with activity resets, plus boundary and noise
                lim = 32'(m_tmo) * 1000;
                r   = $urandom_range(99);
                if (r < 60)
                begin
                    sum = 32'(idle_track) + $urandom_range(lim / 4 + 400);
                    idle_track = (sum > 32'hFFFFF) ? 20'hFFFFF : sum[IdleW-1:0];
                end
                else if (r < 75)
                    idle_track = 20'($urandom_range(199));
                else if (r < 85)
                    idle_track = 20'((lim == 0) ? $urandom_range(1)
                                                : lim - 1 + $urandom_range(2));
                else if (r < 95)
                    idle_track = 20'($urandom);
                else
                    idle_track = 20'hFFFFF;
                send_tick(idle_track, fire, shown);
                if (fire)
                    brightness_q.push_back(shown);
            end
        end

        drain_results();
        $display("covered %0d ticks (directed table, then %0d setting phases with idling and a hold-off)",
                 ticks_sent, PHASES);
        $display("checked %0d brightness updates after %0d register writes, %0d mismatches",
                 updates_seen, reg_writes, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d updates pending", brightness_q.size());
        $display("FAIL");
        $finish;
    end

endmodule
